// ----- rtl/i2c_master_bit_sequencer_top_defines.svh -----
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef I2C_MASTER_BIT_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define I2CMBS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define I2CMBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/i2cmbs_pkg.sv -----
`default_nettype none

package i2cmbs_pkg;

    // Request codes on the input stream
    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_WRITE = 3'd3,
        REQ_READ  = 3'd4,
        REQ_SACK  = 3'd5,
        REQ_RACK  = 3'd6
    } req_t;

    // Active line sequence, one-hot
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_START = 7'b000_0010,
        ST_STOP  = 7'b000_0100,
        ST_WRITE = 7'b000_1000,
        ST_READ  = 7'b001_0000,
        ST_SACK  = 7'b010_0000,
        ST_RACK  = 7'b100_0000
    } cmd_state_t;

    // What the front end made of a beat
    typedef enum logic [1:0] {
        ITEM_NONE = 2'd0,
        ITEM_TICK = 2'd1,
        ITEM_CMD  = 2'd2
    } item_kind_t;

    localparam int unsigned BITS_PER_BYTE  = 8;
    localparam logic [7:0]  BYTE_MSB       = 8'h80;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned S_TDATA_W      = 16;
    localparam int unsigned M_TDATA_W      = 16;

    // Classified item held in the queue
    typedef struct packed {
        item_kind_t kind;
        cmd_state_t cmd;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    // One result beat
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       rx_ack;
        logic       rejected;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/i2cmbs_front.sv -----
`default_nettype none

module i2cmbs_front (
    input  wire logic [2:0]         req_type,
    input  wire logic [7:0]         tx_byte,
    input  wire logic               ack_level,
    input  wire logic               sda_in,
    output i2cmbs_pkg::item_t       item
);
    import i2cmbs_pkg::*;

    // Classify the request and turn it into a sequence selector
    always_comb begin
        item.tx_byte   = tx_byte;
        item.ack_level = ack_level;
        item.sda_in    = sda_in;
        item.kind      = ITEM_CMD;
        item.cmd       = ST_IDLE;
        unique case (req_type)
            REQ_TICK: begin
                item.kind = ITEM_TICK;
            end
            REQ_START: item.cmd = ST_START;
            REQ_STOP:  item.cmd = ST_STOP;
            REQ_WRITE: item.cmd = ST_WRITE;
            REQ_READ:  item.cmd = ST_READ;
            REQ_SACK:  item.cmd = ST_SACK;
            REQ_RACK:  item.cmd = ST_RACK;
            default: begin
                item.kind = ITEM_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/i2cmbs_queue.sv -----
`default_nettype none

module i2cmbs_queue #(
    parameter int unsigned DEPTH = i2cmbs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire i2cmbs_pkg::item_t  push_item,
    output i2cmbs_pkg::q_head_t     head,
    input  wire logic               pop
);
    import i2cmbs_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    item_t           mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the beat, no reset on payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/i2cmbs_back.sv -----
`default_nettype none

module i2cmbs_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire i2cmbs_pkg::q_head_t head,
    output logic                     pop,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output i2cmbs_pkg::result_t      res
);
    import i2cmbs_pkg::*;

    localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);

    cmd_state_t  cmd_reg, cmd_next;
    logic [1:0]  ph_reg, ph_next;
    logic [2:0]  bit_reg, bit_next;
    logic        lead_reg, lead_next;
    logic [7:0]  tx_reg, tx_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ack_hold_reg, ack_hold_next;
    logic        ack_seen_reg, ack_seen_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        res_valid_reg;
    result_t     res_reg, res_next;
    logic        last_act, bit_cmd, done, rej;
    item_t       it;

    assign it        = head.item;
    assign pop       = head.valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign bit_cmd   = (cmd_reg == ST_WRITE) || (cmd_reg == ST_READ);

    // Carry out one beat: a pin action, a command load or nothing
    always_comb begin
        cmd_next      = cmd_reg;
        ph_next       = ph_reg;
        bit_next      = bit_reg;
        lead_next     = lead_reg;
        tx_next       = tx_reg;
        rx_next       = rx_reg;
        ack_hold_next = ack_hold_reg;
        ack_seen_next = ack_seen_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        last_act      = 1'b0;
        done          = 1'b0;
        rej           = 1'b0;

        if (pop) begin
            case (it.kind)
                ITEM_TICK: begin
                    // Pin action of the loaded sequence
                    unique case (cmd_reg)
                        ST_START: begin
                            case (ph_reg)
                                2'd0:    sda_next = 1'b1;
                                2'd1:    scl_next = 1'b1;
                                2'd2:    sda_next = 1'b0;
                                default: scl_next = 1'b0;
                            endcase
                            last_act = (ph_reg == 2'd3);
                        end
                        ST_STOP: begin
                            case (ph_reg)
                                2'd0:    sda_next = 1'b0;
                                2'd1:    scl_next = 1'b1;
                                default: sda_next = 1'b1;
                            endcase
                            last_act = (ph_reg == 2'd2);
                        end
                        ST_WRITE: begin
                            case (ph_reg)
                                2'd0:    sda_next = tx_reg[~bit_reg];
                                2'd1:    scl_next = 1'b1;
                                default: scl_next = 1'b0;
                            endcase
                            last_act = (bit_reg == LAST_BIT) && (ph_reg == 2'd2);
                        end
                        ST_READ: begin
                            if (lead_reg) begin
                                sda_next = 1'b1;
                            end else begin
                                case (ph_reg)
                                    2'd0: scl_next = 1'b1;
                                    2'd1: begin
                                        if (it.sda_in) begin
                                            rx_next = rx_reg | (BYTE_MSB >> bit_reg);
                                        end
                                    end
                                    default: scl_next = 1'b0;
                                endcase
                                last_act = (bit_reg == LAST_BIT) && (ph_reg == 2'd2);
                            end
                        end
                        ST_SACK: begin
                            case (ph_reg)
                                2'd0:    sda_next = ack_hold_reg;
                                2'd1:    scl_next = 1'b1;
                                default: scl_next = 1'b0;
                            endcase
                            last_act = (ph_reg == 2'd2);
                        end
                        ST_RACK: begin
                            case (ph_reg)
                                2'd0:    sda_next = 1'b1;
                                2'd1:    scl_next = 1'b1;
                                2'd2:    ack_seen_next = it.sda_in;
                                default: scl_next = 1'b0;
                            endcase
                            last_act = (ph_reg == 2'd3);
                        end
                        default: ;
                    endcase

                    // Advance the step, drop back to idle after the last action
                    if (cmd_reg != ST_IDLE) begin
                        if (last_act) begin
                            cmd_next = ST_IDLE;
                            ph_next  = '0;
                            bit_next = '0;
                            done     = 1'b1;
                        end else if (lead_reg) begin
                            lead_next = 1'b0;
                        end else if (bit_cmd && (ph_reg == 2'd2)) begin
                            ph_next  = '0;
                            bit_next = bit_reg + 1'b1;
                        end else begin
                            ph_next = ph_reg + 1'b1;
                        end
                    end
                end
                ITEM_CMD: begin
                    // Load a sequence only while idle
                    if (cmd_reg != ST_IDLE) begin
                        rej = 1'b1;
                    end else begin
                        cmd_next  = it.cmd;
                        ph_next   = '0;
                        bit_next  = '0;
                        lead_next = (it.cmd == ST_READ);
                        if (it.cmd == ST_WRITE) begin
                            tx_next = it.tx_byte;
                        end
                        if (it.cmd == ST_READ) begin
                            rx_next = '0;
                        end
                        if (it.cmd == ST_SACK) begin
                            ack_hold_next = it.ack_level;
                        end
                    end
                end
                default: ;
            endcase
        end

        res_next.scl_level = scl_next;
        res_next.sda_level = sda_next;
        res_next.busy_res  = (cmd_next != ST_IDLE);
        res_next.done_res  = done;
        res_next.rx_byte   = rx_next;
        res_next.rx_ack    = ack_seen_next;
        res_next.rejected  = rej;
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg       <= ST_IDLE;
            ph_reg        <= '0;
            bit_reg       <= '0;
            lead_reg      <= 1'b0;
            tx_reg        <= '0;
            rx_reg        <= '0;
            ack_hold_reg  <= 1'b0;
            ack_seen_reg  <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            res_valid_reg <= 1'b0;
        end else begin
            cmd_reg       <= cmd_next;
            ph_reg        <= ph_next;
            bit_reg       <= bit_next;
            lead_reg      <= lead_next;
            tx_reg        <= tx_next;
            rx_reg        <= rx_next;
            ack_hold_reg  <= ack_hold_next;
            ack_seen_reg  <= ack_seen_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            if (pop) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/i2c_master_bit_sequencer_top.sv -----
// I2C master bit sequencer. A command beat (start, stop, write byte, read byte,
// send ack, receive ack) loads a line sequence while the sequencer is idle and
// is flagged as rejected otherwise; each following tick beat performs one pin
// action on SCL/SDA and returns the line state, busy/done flags, the read shift
// register and the sampled ack. Every input beat gives exactly one result beat.
// The block takes one beat per clock on each side: a small queue (QUEUE_DEPTH
// entries) sits between the classifying front end and the sequencer, and the
// result is held in an output register, so each beat passes the queue and then
// the output register; either side may stall without stopping the other until
// the queue is full. After reset both lines read released high.
`default_nettype none
`include "i2c_master_bit_sequencer_top_defines.svh"

module i2c_master_bit_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = i2cmbs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] req_type, [10:3] tx_byte, [11] ack_level, [12] sda_in, rest zero
    input  wire logic [i2cmbs_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] rx_ack, [13] rejected, rest zero
    output logic [i2cmbs_pkg::M_TDATA_W-1:0]       m_tdata
);
    import i2cmbs_pkg::*;

    item_t    front_item;
    q_head_t  q_head;
    logic     q_pop;
    result_t  res;

    // Classify the incoming beat
    i2cmbs_front u_front (
        .req_type  (s_tdata[2:0]),
        .tx_byte   (s_tdata[10:3]),
        .ack_level (s_tdata[11]),
        .sda_in    (s_tdata[12]),
        .item      (front_item)
    );

    // Decouple front end from sequencer
    i2cmbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .head       (q_head),
        .pop        (q_pop)
    );

    // Run the line sequences
    i2cmbs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .pop       (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result beat
    assign m_tdata = {2'b00, res.rejected, res.rx_ack, res.rx_byte,
                      res.done_res, res.busy_res, res.sda_level, res.scl_level};

    `I2CMBS_ASSERT_IMPLY(a_done_idle, aclk, aresetn, m_tvalid && res.done_res,
        !res.busy_res, "done beat while still busy")
    `I2CMBS_ASSERT_IMPLY(a_rej_busy, aclk, aresetn, m_tvalid && res.rejected,
        res.busy_res && !res.done_res, "rejected beat while idle or done")
    `I2CMBS_ASSERT_IMPLY(a_pop_room, aclk, aresetn, q_pop,
        q_head.valid && (!m_tvalid || m_tready), "queue popped without room")
    `I2CMBS_ASSERT_NEXT(a_pop_result, aclk, aresetn, q_pop,
        m_tvalid, "popped beat gave no result")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import i2cmbs_pkg::*;

    // Request code 7 is not a command: the block must neither load nor reject it
    localparam logic [2:0]  REQ_UNUSED    = 3'd7;
    // The sequencer is idle when no command is loaded, which shares the tick code
    localparam logic [2:0]  SEQ_IDLE      = REQ_TICK;
    localparam int unsigned MAX_GAP       = 14;
    localparam int unsigned RANDOM_ITEMS  = 1750;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned HOLD_AT_BEAT  = 500;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LIMIT_CYCLES  = 400000;

    typedef struct packed {
        logic [2:0] req;
        logic [7:0] txb;
        logic       ackl;
        logic       sdai;
        logic       drain;    // wait for every result before offering this beat
    } bus_item_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    bus_item_t   pending[$];
    result_t     line_results[$];
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;

    // Sequencer state mirrored by the testbench
    logic [2:0] act_cmd  = SEQ_IDLE;
    logic [4:0] act_step = '0;
    logic [7:0] tx_sh    = '0;
    logic [7:0] rx_sh    = '0;
    logic       ack_hold = 1'b0;
    logic       ack_seen = 1'b0;
    logic       scl_q    = 1'b1;
    logic       sda_q    = 1'b1;

    // Driver and monitor bookkeeping
    bus_item_t   next_item;
    result_t     next_result;
    int unsigned send_gap   = 0;
    logic        send_calm  = 1'b0;
    int unsigned recv_wait  = 0;
    int unsigned recv_draw  = 0;
    logic        recv_calm  = 1'b0;
    int unsigned beats_seen = 0;

    i2c_master_bit_sequencer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [4:0] sequence_ticks(input logic [2:0] cmd);
        case (cmd)
            REQ_START: return 5'd4;
            REQ_STOP:  return 5'd3;
            REQ_WRITE: return 5'd24;
            REQ_READ:  return 5'd25;
            REQ_SACK:  return 5'd3;
            REQ_RACK:  return 5'd4;
            default:   return 5'd0;
        endcase
    endfunction

    // Perform one pin action of the loaded sequence
    task automatic pin_action(input logic sdai);
        int unsigned t;
        int unsigned bitn;
        int unsigned ph;
        t = act_step;
        case (act_cmd)
            REQ_START: begin
                case (t)
                    0:       sda_q = 1'b1;
                    1:       scl_q = 1'b1;
                    2:       sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
            end
            REQ_STOP: begin
                case (t)
                    0:       sda_q = 1'b0;
                    1:       scl_q = 1'b1;
                    default: sda_q = 1'b1;
                endcase
            end
            REQ_WRITE: begin
                bitn = (t / 3) % BITS_PER_BYTE;
                ph   = t % 3;
                if (ph == 0) sda_q = (tx_sh & (BYTE_MSB >> bitn)) != 8'h00;
                else if (ph == 1) scl_q = 1'b1;
                else scl_q = 1'b0;
            end
            REQ_READ: begin
                if (t == 0) begin
                    sda_q = 1'b1;
                end else begin
                    bitn = ((t - 1) / 3) % BITS_PER_BYTE;
                    ph   = (t - 1) % 3;
                    if (ph == 0) scl_q = 1'b1;
                    else if (ph == 1) begin
                        if (sdai) rx_sh = rx_sh | (BYTE_MSB >> bitn);
                    end else scl_q = 1'b0;
                end
            end
            REQ_SACK: begin
                case (t)
                    0:       sda_q = ack_hold;
                    1:       scl_q = 1'b1;
                    default: scl_q = 1'b0;
                endcase
            end
            REQ_RACK: begin
                case (t)
                    0:       sda_q = 1'b1;
                    1:       scl_q = 1'b1;
                    2:       ack_seen = sdai;
                    default: scl_q = 1'b0;
                endcase
            end
            default: ;
        endcase
    endtask

    // Advance the mirrored sequencer by one beat and form the line state it reports
    task automatic line_step(input bus_item_t it, output result_t r);
        logic busy;
        logic done;
        logic rej;
        busy = act_cmd != SEQ_IDLE;
        done = 1'b0;
        rej  = 1'b0;
        if (it.req == REQ_TICK) begin
            if (busy) begin
                pin_action(it.sdai);
                act_step = act_step + 5'd1;
                if (act_step >= sequence_ticks(act_cmd)) begin
                    act_cmd  = SEQ_IDLE;
                    act_step = '0;
                    done     = 1'b1;
                end
            end
        end else if (it.req != REQ_UNUSED) begin
            if (busy) begin
                rej = 1'b1;
            end else begin
                act_cmd  = it.req;
                act_step = '0;
                if (it.req == REQ_WRITE) tx_sh = it.txb;
                if (it.req == REQ_READ) rx_sh = '0;
                if (it.req == REQ_SACK) ack_hold = it.ackl;
            end
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res  = act_cmd != SEQ_IDLE;
        r.done_res  = done;
        r.rx_byte   = rx_sh;
        r.rx_ack    = ack_seen;
        r.rejected  = rej;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_line_result(input logic [M_TDATA_W-1:0] d);
        result_t want;
        if (line_results.size() == 0) begin
            $error("result beat %h with nothing outstanding", d);
            mismatches++;
        end else begin
            want = line_results.pop_front();
            compare_field("scl_level", want.scl_level, d[0]);
            compare_field("sda_level", want.sda_level, d[1]);
            compare_field("busy_res", want.busy_res, d[2]);
            compare_field("done_res", want.done_res, d[3]);
            compare_field("rx_byte", want.rx_byte, d[11:4]);
            compare_field("rx_ack", want.rx_ack, d[12]);
            compare_field("rejected", want.rejected, d[13]);
        end
    endtask

    task automatic queue_item(input logic [2:0] req, input logic [7:0] txb,
                              input logic ackl, input logic sdai, input logic drain);
        bus_item_t it;
        it.req   = req;
        it.txb   = txb;
        it.ackl  = ackl;
        it.sdai  = sdai;
        it.drain = drain;
        pending.push_back(it);
    endtask

    // Tick beats carry random junk in the fields that only commands use
    task automatic queue_tick(input logic sdai);
        queue_item(REQ_TICK, 8'($urandom), 1'($urandom), sdai, 1'b0);
    endtask

    task automatic queue_stray(input logic [2:0] req);
        queue_item(req, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
    endtask

    // Issue one command with its ticks, salted with stray and unused beats; now and
    // then cut the ticks short so the next command meets a busy block, or add a tick
    task automatic queue_sequence(input logic [2:0] cmd, input logic drain,
                                  inout int unsigned live);
        logic [7:0]  txb;
        int unsigned n;
        int unsigned k;
        int unsigned noise;
        int unsigned sda_mode;
        logic        sdai;
        case ($urandom_range(7))
            0:       txb = 8'h00;
            1:       txb = 8'hFF;
            default: txb = 8'($urandom);
        endcase
        sda_mode = $urandom_range(3);
        queue_item(cmd, txb, 1'($urandom), 1'($urandom), drain);
        live++;
        n = sequence_ticks(cmd);
        if ($urandom_range(9) == 0) n = $urandom_range(n - 1);
        for (k = 0; k < n; k++) begin
            noise = $urandom_range(15);
            if (noise == 0) begin
                queue_stray(3'($urandom_range(REQ_RACK, REQ_START)));
                live++;
            end else if (noise == 1) begin
                queue_stray(REQ_UNUSED);
                live++;
            end
            if (sda_mode == 0) sdai = 1'b0;
            else if (sda_mode == 1) sdai = 1'b1;
            else sdai = 1'($urandom);
            queue_tick(sdai);
            live++;
        end
        if ($urandom_range(3) == 0) begin
            queue_tick(1'($urandom));
            live++;
        end
    endtask

    // Sender: hold a beat until taken, then wait out the drawn gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_tvalid && !s_tready) begin
            // hold the beat
        end else if (send_gap != 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending.size() != 0 &&
                     (!pending[0].drain || line_results.size() == 0)) begin
            next_item = pending.pop_front();
            line_step(next_item, next_result);
            line_results.push_back(next_result);
            s_tdata  <= {3'b000, next_item.sdai, next_item.ackl, next_item.txb,
                         next_item.req};
            s_tvalid <= 1'b1;
            if ($urandom_range(63) == 0) send_calm <= !send_calm;
            send_gap <= send_calm ? 0 : $urandom_range(MAX_GAP);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: check each beat, then stall for the drawn number of cycles;
    // one long hold lets the block fill up and back-pressure the sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            check_line_result(m_tdata);
            beats_seen <= beats_seen + 1;
            if (beats_seen + 1 == HOLD_AT_BEAT) recv_draw = LONG_HOLD;
            else recv_draw = recv_calm ? 0 : $urandom_range(MAX_GAP);
            if ($urandom_range(63) == 0) recv_calm <= !recv_calm;
            m_tready  <= recv_draw == 0;
            recv_wait <= (recv_draw == 0) ? 0 : recv_draw - 1;
        end else if (recv_wait != 0) begin
            m_tready  <= 1'b0;
            recv_wait <= recv_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned live;
        int unsigned seq_no;
        live   = 0;
        seq_no = 0;

        // Idle tick and unused code while idle: nothing moves
        queue_item(REQ_TICK, 8'hFF, 1'b1, 1'b1, 1'b0);
        queue_item(REQ_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b0);
        // Start, with a command and an unused code arriving while busy
        queue_item(REQ_START, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_item(REQ_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_item(REQ_UNUSED, 8'h00, 1'b0, 1'b0, 1'b0);
        repeat (4) queue_tick(1'b0);
        // Stop
        queue_item(REQ_STOP, 8'hFF, 1'b1, 1'b1, 1'b0);
        repeat (3) queue_tick(1'b1);
        // Send a nack level
        queue_item(REQ_SACK, 8'h00, 1'b1, 1'b0, 1'b0);
        repeat (3) queue_tick(1'b0);
        // Receive ack, sampling a low line
        queue_item(REQ_RACK, 8'hFF, 1'b0, 1'b1, 1'b0);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);

        // Random part: mostly whole sequences, drained now and then
        while (live < RANDOM_ITEMS) begin
            queue_sequence(3'($urandom_range(REQ_RACK, REQ_START)),
                           seq_no % 30 == 0, live);
            seq_no++;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || line_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
